>>> rtl/lix_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lix_pkg
// Shared widths, payload structs and inter-stage types for the 2-D line
// intersection pipeline.
// ----------------------------------------------------------------------------
package lix_pkg;

    localparam int COORD_W = 32;
    // line coefficient widths at exact precision
    localparam int AW  = COORD_W + 1;       // a = dy, b = -dx
    localparam int MW  = 2 * COORD_W;       // coordinate products
    localparam int CW  = 2 * COORD_W + 1;   // c
    localparam int QW  = 2 * AW;            // a*b and partial a*c products
    localparam int DW  = QW + 1;            // determinant
    localparam int PW  = AW + CW;           // full a*c product
    localparam int NW  = PW + 1;            // numerators and divider datapath

    localparam int COEF_LAT = 3;
    localparam int NUM_LAT  = 3;
    localparam int DIV_LAT  = COORD_W + 1;
    localparam int PIPE_LAT = COEF_LAT + NUM_LAT + DIV_LAT + 1;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        t_coord first_start_x;
        t_coord first_start_y;
        t_coord first_end_x;
        t_coord first_end_y;
        t_coord second_start_x;
        t_coord second_start_y;
        t_coord second_end_x;
        t_coord second_end_y;
    } t_in;

    typedef struct packed {
        logic   hit_valid;
        t_coord hit_x;
        t_coord hit_y;
        logic   saturated;
    } t_out;

    typedef struct packed {
        logic signed [AW-1:0] a1;
        logic signed [AW-1:0] b1;
        logic signed [AW-1:0] a2;
        logic signed [AW-1:0] b2;
        logic signed [CW-1:0] c1;
        logic signed [CW-1:0] c2;
        logic signed [DW-1:0] det;
    } t_coef;

    typedef struct packed {
        logic [NW-1:0] nx_mag;
        logic [NW-1:0] ny_mag;
        logic [NW-1:0] den_mag;
        logic          nx_neg;
        logic          ny_neg;
        logic          det_zero;
    } t_numer;

endpackage

>>> rtl/line_intersection_2d_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_intersection_2d_unit
// Intersection point of two infinite lines in signed Q16.16.
// ----------------------------------------------------------------------------
// One transfer in, one transfer out, one item per cycle sustained while the
// output is not stalled. The pipeline has 40 register stages: three
// coefficient stages, three numerator stages, a 33-stage divider (one range
// check plus one quotient bit per stage) and the output register. The whole
// pipeline moves together whenever the output register is empty or being
// taken, so a stall holds every stage in place. Parallel or degenerate
// lines give hit_valid low and zero coordinates; out-of-range quotients
// clamp and raise saturated.
module line_intersection_2d_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  lix_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output lix_pkg::t_out o_out_data
);

    localparam int W   = lix_pkg::COORD_W;
    localparam int LAT = lix_pkg::PIPE_LAT;

    // pipeline advance
    logic en;

    // valid bits, last one is the output register
    logic [LAT-1:0] r_vld;

    lix_pkg::t_coef  coef;
    lix_pkg::t_numer numer;

    // divider results
    logic [W-1:0] qx, qy;
    logic         ovfx, ovfy, negx, negy;

    // parallel flag delayed alongside the dividers
    logic r_dz [0:W];

    // output formatting
    logic   satx, saty;
    lix_pkg::t_coord vx, vy;
    lix_pkg::t_out   n_out, r_out;

    assign en         = !r_vld[LAT-1] || i_out_ready;
    assign o_in_ready = en;

    lix_coef u_coef (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_data (i_in_data),
        .o_coef (coef)
    );

    lix_num u_num (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_coef  (coef),
        .o_numer (numer)
    );

    lix_div u_div_x (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (numer.nx_mag),
        .i_den  (numer.den_mag),
        .i_neg  (numer.nx_neg),
        .o_quot (qx),
        .o_ovf  (ovfx),
        .o_neg  (negx)
    );

    lix_div u_div_y (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (numer.ny_mag),
        .i_den  (numer.den_mag),
        .i_neg  (numer.ny_neg),
        .o_quot (qy),
        .o_ovf  (ovfy),
        .o_neg  (negy)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dz[0] <= numer.det_zero;
            for (int i = 1; i <= W; i++) begin
                r_dz[i] <= r_dz[i-1];
            end
        end
    end

    // clamp: negative limit is 2^(W-1), positive limit 2^(W-1)-1
    always_comb begin
        satx = ovfx || (negx ? (qx[W-1] && (qx[W-2:0] != '0)) : qx[W-1]);
        saty = ovfy || (negy ? (qy[W-1] && (qy[W-2:0] != '0)) : qy[W-1]);
        if (satx) begin
            vx = negx ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end else begin
            vx = negx ? -$signed(qx) : $signed(qx);
        end
        if (saty) begin
            vy = negy ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end else begin
            vy = negy ? -$signed(qy) : $signed(qy);
        end
        if (r_dz[W]) begin
            n_out = '0;
        end else begin
            n_out.hit_valid = 1'b1;
            n_out.hit_x     = vx;
            n_out.hit_y     = vy;
            n_out.saturated = satx || saty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_vld[LAT-1];
    assign o_out_data  = r_out;

    // parallel result carries no coordinates
    a_parallel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.hit_valid |->
            o_out_data.hit_x == '0 && o_out_data.hit_y == '0 && !o_out_data.saturated)
        else $error("parallel result with nonzero fields");

    // clamping only happens on a real intersection
    a_sat_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.saturated |-> o_out_data.hit_valid)
        else $error("saturated set without a hit");

    // an accepted transfer enters the first valid stage
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_vld[0])
        else $error("accepted transfer lost at pipeline entry");

endmodule

>>> rtl/lix_coef.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lix_coef
// Three stages: line deltas, coordinate and determinant products, then
// the c coefficients and the determinant.
// ----------------------------------------------------------------------------
module lix_coef (
    input  logic           i_clk,
    input  logic           i_en,
    input  lix_pkg::t_in   i_data,
    output lix_pkg::t_coef o_coef
);

    localparam int W  = lix_pkg::COORD_W;
    localparam int AW = lix_pkg::AW;
    localparam int MW = lix_pkg::MW;
    localparam int QW = lix_pkg::QW;

    // stage 1
    lix_pkg::t_in         r_pts;
    logic signed [AW-1:0] r1_a1, r1_b1, r1_a2, r1_b2;
    logic signed [AW-1:0] n_a1, n_b1, n_a2, n_b2;
    // stage 2
    logic signed [MW-1:0] r_m1a, r_m1b, r_m2a, r_m2b;
    logic signed [QW-1:0] r_pd1, r_pd2;
    logic signed [AW-1:0] r2_a1, r2_b1, r2_a2, r2_b2;
    // stage 3
    lix_pkg::t_coef       r_coef;

    always_comb begin
        n_a1 = $signed({i_data.first_end_y[W-1], i_data.first_end_y})
             - $signed({i_data.first_start_y[W-1], i_data.first_start_y});
        n_b1 = $signed({i_data.first_start_x[W-1], i_data.first_start_x})
             - $signed({i_data.first_end_x[W-1], i_data.first_end_x});
        n_a2 = $signed({i_data.second_end_y[W-1], i_data.second_end_y})
             - $signed({i_data.second_start_y[W-1], i_data.second_start_y});
        n_b2 = $signed({i_data.second_start_x[W-1], i_data.second_start_x})
             - $signed({i_data.second_end_x[W-1], i_data.second_end_x});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pts <= i_data;
            r1_a1 <= n_a1;
            r1_b1 <= n_b1;
            r1_a2 <= n_a2;
            r1_b2 <= n_b2;

            r_m1a <= $signed(r_pts.first_end_x) * $signed(r_pts.first_start_y);
            r_m1b <= $signed(r_pts.first_start_x) * $signed(r_pts.first_end_y);
            r_m2a <= $signed(r_pts.second_end_x) * $signed(r_pts.second_start_y);
            r_m2b <= $signed(r_pts.second_start_x) * $signed(r_pts.second_end_y);
            r_pd1 <= r1_a1 * r1_b2;
            r_pd2 <= r1_a2 * r1_b1;
            r2_a1 <= r1_a1;
            r2_b1 <= r1_b1;
            r2_a2 <= r1_a2;
            r2_b2 <= r1_b2;

            r_coef.a1  <= r2_a1;
            r_coef.b1  <= r2_b1;
            r_coef.a2  <= r2_a2;
            r_coef.b2  <= r2_b2;
            r_coef.c1  <= $signed({r_m1a[MW-1], r_m1a}) - $signed({r_m1b[MW-1], r_m1b});
            r_coef.c2  <= $signed({r_m2a[MW-1], r_m2a}) - $signed({r_m2b[MW-1], r_m2b});
            r_coef.det <= $signed({r_pd1[QW-1], r_pd1}) - $signed({r_pd2[QW-1], r_pd2});
        end
    end

    assign o_coef = r_coef;

endmodule

>>> rtl/lix_num.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lix_num
// Three stages: split partial products of a*c and b*c, recombination,
// then numerator difference and sign/magnitude for the dividers.
// ----------------------------------------------------------------------------
module lix_num (
    input  logic            i_clk,
    input  logic            i_en,
    input  lix_pkg::t_coef  i_coef,
    output lix_pkg::t_numer o_numer
);

    localparam int W  = lix_pkg::COORD_W;
    localparam int AW = lix_pkg::AW;
    localparam int CW = lix_pkg::CW;
    localparam int QW = lix_pkg::QW;
    localparam int DW = lix_pkg::DW;
    localparam int PW = lix_pkg::PW;
    localparam int NW = lix_pkg::NW;

    // c split into an unsigned low half and a signed high half
    logic signed [AW-1:0] c1_lo, c1_hi, c2_lo, c2_hi;

    // stage 4: partial products, index 0 = b1*c2, 1 = b2*c1, 2 = a2*c1, 3 = a1*c2
    logic signed [QW-1:0] r_plo [0:3];
    logic signed [QW-1:0] r_phi [0:3];
    logic signed [DW-1:0] r4_det;
    // stage 5
    logic signed [PW-1:0] r_full [0:3];
    logic signed [DW-1:0] r5_det;
    // stage 6
    logic signed [NW-1:0] nx, ny;
    lix_pkg::t_numer      r_numer;

    assign c1_lo = $signed({1'b0, i_coef.c1[W-1:0]});
    assign c1_hi = $signed(i_coef.c1[CW-1:W]);
    assign c2_lo = $signed({1'b0, i_coef.c2[W-1:0]});
    assign c2_hi = $signed(i_coef.c2[CW-1:W]);

    assign nx = $signed({r_full[0][PW-1], r_full[0]}) - $signed({r_full[1][PW-1], r_full[1]});
    assign ny = $signed({r_full[2][PW-1], r_full[2]}) - $signed({r_full[3][PW-1], r_full[3]});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_plo[0] <= i_coef.b1 * c2_lo;
            r_phi[0] <= i_coef.b1 * c2_hi;
            r_plo[1] <= i_coef.b2 * c1_lo;
            r_phi[1] <= i_coef.b2 * c1_hi;
            r_plo[2] <= i_coef.a2 * c1_lo;
            r_phi[2] <= i_coef.a2 * c1_hi;
            r_plo[3] <= i_coef.a1 * c2_lo;
            r_phi[3] <= i_coef.a1 * c2_hi;
            r4_det   <= i_coef.det;

            for (int i = 0; i < 4; i++) begin
                r_full[i] <= $signed({r_phi[i], {W{1'b0}}})
                           + $signed({{W{r_plo[i][QW-1]}}, r_plo[i]});
            end
            r5_det <= r4_det;

            r_numer.nx_mag   <= nx[NW-1] ? NW'(-nx) : NW'(nx);
            r_numer.ny_mag   <= ny[NW-1] ? NW'(-ny) : NW'(ny);
            r_numer.den_mag  <= NW'(r5_det[DW-1] ? DW'(-r5_det) : DW'(r5_det));
            r_numer.nx_neg   <= nx[NW-1] ^ r5_det[DW-1];
            r_numer.ny_neg   <= ny[NW-1] ^ r5_det[DW-1];
            r_numer.det_zero <= (r5_det == '0);
        end
    end

    assign o_numer = r_numer;

endmodule

>>> rtl/lix_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lix_div
// Pipelined restoring divider: one range check stage, then one quotient
// bit per stage, magnitudes only.
// ----------------------------------------------------------------------------
module lix_div (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [lix_pkg::NW-1:0]      i_num,
    input  logic [lix_pkg::NW-1:0]      i_den,
    input  logic                        i_neg,
    output logic [lix_pkg::COORD_W-1:0] o_quot,
    output logic                        o_ovf,
    output logic                        o_neg
);

    localparam int W  = lix_pkg::COORD_W;
    localparam int NW = lix_pkg::NW;

    logic [NW-1:0] r_rem [0:W];
    logic [NW-1:0] r_den [0:W];
    logic [W-1:0]  r_q   [0:W];
    logic          r_ovf [0:W];
    logic          r_neg [0:W];

    // per-stage trial subtraction
    logic [NW-1:0] shifted [1:W];
    logic [W:1]    ge;
    logic [W-1:0]  n_q     [1:W];

    always_comb begin
        for (int j = 1; j <= W; j++) begin
            shifted[j]     = r_den[j-1] << (W - j);
            ge[j]          = (r_rem[j-1] >= shifted[j]);
            n_q[j]         = r_q[j-1];
            n_q[j][W - j]  = ge[j];
        end
    end

    // quotient of more than W bits cannot be represented
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num;
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_ovf[0] <= (i_num >= (i_den << W));
            r_neg[0] <= i_neg;
            for (int j = 1; j <= W; j++) begin
                r_rem[j] <= ge[j] ? (r_rem[j-1] - shifted[j]) : r_rem[j-1];
                r_den[j] <= r_den[j-1];
                r_q[j]   <= n_q[j];
                r_ovf[j] <= r_ovf[j-1];
                r_neg[j] <= r_neg[j-1];
            end
        end
    end

    assign o_quot = r_q[W];
    assign o_ovf  = r_ovf[W];
    assign o_neg  = r_neg[W];

endmodule

>>> tb/tb_line_intersection_2d_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_line_intersection_2d_unit
// Self-checking bench for the 2-D line intersection pipeline: random and
// directed line pairs go in over valid/ready, each result transfer is checked
// against an exact-width prediction of the intersection point.
// ----------------------------------------------------------------------------
module tb_line_intersection_2d_unit;

    localparam int N_RANDOM    = 1600;
    localparam int CYCLE_LIMIT = 400000;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_in_valid = 1'b0;
    logic  o_in_ready;
    lix_pkg::t_in   i_in_data = '0;
    logic  o_out_valid;
    logic  i_out_ready = 1'b0;
    lix_pkg::t_out  o_out_data;

    lix_pkg::t_in   pending_lines[$];
    lix_pkg::t_out  expected_hits[$];
    int    n_sent = 0;
    int    n_checked = 0;
    int    n_parallel = 0;
    int    n_clamped = 0;
    int    n_mismatch = 0;
    int    cycle_count = 0;
    bit    stim_done = 1'b0;
    bit    calm_phase = 1'b0;

    line_intersection_2d_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #4 i_clk = ~i_clk;

    // clamp one exact quotient to the coordinate range
    function automatic lix_pkg::t_coord clamp_coord(input logic signed [255:0] q,
                                                    inout logic sat);
        logic signed [255:0] hi, lo;
        hi = 256'sd2147483647;
        lo = -256'sd2147483648;
        if (q > hi) begin
            sat = 1'b1;
            return lix_pkg::t_coord'(hi[31:0]);
        end
        if (q < lo) begin
            sat = 1'b1;
            return lix_pkg::t_coord'(lo[31:0]);
        end
        return lix_pkg::t_coord'(q[31:0]);
    endfunction

    // exact intersection point; SV signed division truncates toward zero
    function automatic lix_pkg::t_out intersect_lines(input lix_pkg::t_in p);
        logic signed [255:0] s1x, s1y, e1x, e1y, s2x, s2y, e2x, e2y;
        logic signed [255:0] a1, b1, c1, a2, b2, c2, det, nx, ny;
        lix_pkg::t_out r;
        logic sat;
        s1x = p.first_start_x;  s1y = p.first_start_y;
        e1x = p.first_end_x;    e1y = p.first_end_y;
        s2x = p.second_start_x; s2y = p.second_start_y;
        e2x = p.second_end_x;   e2y = p.second_end_y;
        a1 = e1y - s1y;  b1 = s1x - e1x;  c1 = e1x * s1y - s1x * e1y;
        a2 = e2y - s2y;  b2 = s2x - e2x;  c2 = e2x * s2y - s2x * e2y;
        det = a1 * b2 - a2 * b1;
        r = '0;
        if (det == 0) return r;
        nx = b1 * c2 - b2 * c1;
        ny = a2 * c1 - a1 * c2;
        sat = 1'b0;
        r.hit_valid = 1'b1;
        r.hit_x = clamp_coord(nx / det, sat);
        r.hit_y = clamp_coord(ny / det, sat);
        r.saturated = sat;
        return r;
    endfunction

    function automatic lix_pkg::t_coord rand_coord();
        case ($urandom_range(0, 5))
            0: return lix_pkg::t_coord'($urandom);
            1: return lix_pkg::t_coord'($signed($urandom_range(0, 20)) - 10) <<< 16;
            2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            3: return lix_pkg::t_coord'($signed($urandom_range(0, 2000)) - 1000);
            default: return lix_pkg::t_coord'($signed($urandom_range(0, 65535)) - 32768) <<< 4;
        endcase
    endfunction

    function automatic lix_pkg::t_in rand_lines();
        lix_pkg::t_in p;
        int dx, dy, k;
        p.first_start_x = rand_coord();  p.first_start_y = rand_coord();
        p.first_end_x = rand_coord();    p.first_end_y = rand_coord();
        p.second_start_x = rand_coord(); p.second_start_y = rand_coord();
        p.second_end_x = rand_coord();   p.second_end_y = rand_coord();
        case ($urandom_range(0, 9))
            // parallel: second line direction is a multiple of the first
            0: begin
                dx = $signed($urandom_range(0, 2000)) - 1000;
                dy = $signed($urandom_range(0, 2000)) - 1000;
                k  = $signed($urandom_range(0, 6)) - 3;
                p.first_end_x  = p.first_start_x + dx;
                p.first_end_y  = p.first_start_y + dy;
                p.second_end_x = p.second_start_x + k * dx;
                p.second_end_y = p.second_start_y + k * dy;
            end
            // degenerate first line
            1: begin
                p.first_end_x = p.first_start_x;
                p.first_end_y = p.first_start_y;
            end
            // nearly parallel, can drive the quotient out of range
            2: begin
                p.first_start_x = 0; p.first_start_y = 0;
                p.first_end_x = 32'sh10000; p.first_end_y = 1;
                p.second_start_x = 0; p.second_start_y = rand_coord();
                p.second_end_x = 32'sh10000; p.second_end_y = p.second_start_y;
            end
            default: ;
        endcase
        return p;
    endfunction

    function automatic lix_pkg::t_in make_lines(input lix_pkg::t_coord a, b, c, d,
                                                e, f, g, h);
        lix_pkg::t_in p;
        p.first_start_x = a;  p.first_start_y = b;
        p.first_end_x = c;    p.first_end_y = d;
        p.second_start_x = e; p.second_start_y = f;
        p.second_end_x = g;   p.second_end_y = h;
        return p;
    endfunction

    initial begin
        lix_pkg::t_coord mx, mn;
        mx = 32'sh7fffffff;
        mn = 32'sh80000000;
        // axis crossing at origin, offset crossing, fractional point
        pending_lines.push_back(make_lines(-65536, 0, 65536, 0, 0, -65536, 0, 65536));
        pending_lines.push_back(make_lines(0, 0, 65536, 65536, 0, 65536, 65536, 0));
        pending_lines.push_back(make_lines(0, 3, 7, 3, 5, 0, 5, 11));
        // parallel, coincident, degenerate lines
        pending_lines.push_back(make_lines(0, 0, 65536, 0, 0, 65536, 65536, 65536));
        pending_lines.push_back(make_lines(0, 0, 10, 10, 20, 20, 30, 30));
        pending_lines.push_back(make_lines(5, 5, 5, 5, 0, 0, 1, 7));
        pending_lines.push_back(make_lines(1, 2, 3, 4, 9, 9, 9, 9));
        // coordinate extremes
        pending_lines.push_back(make_lines(mn, mn, mx, mx, mn, mx, mx, mn));
        pending_lines.push_back(make_lines(mx, mn, mn, mx, mx, mx, mn, mn));
        pending_lines.push_back(make_lines(mx, mx, mx, mn, mn, mn, mx, mn));
        pending_lines.push_back(make_lines(mn, 0, mx, 1, 0, 0, mx, 0));
        pending_lines.push_back(make_lines(-1, -1, -1, -1, -1, -1, -1, -1));
        // quotient clamped high, clamped low
        pending_lines.push_back(make_lines(0, 0, 65536, 1, 0, mx, 65536, mx));
        pending_lines.push_back(make_lines(0, 0, 65536, 1, 0, mn, 65536, mn));
        pending_lines.push_back(make_lines(0, 0, -65536, 1, 0, mx, 65536, mx));
        for (int i = 0; i < N_RANDOM; i++) pending_lines.push_back(rand_lines());
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_lines.size() == 0 && !i_in_valid);
        stim_done = 1'b1;
    end

    // quiet window with no idling on either side
    always @(posedge i_clk) calm_phase <= (cycle_count > 600 && cycle_count < 1200);

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || o_in_ready) begin
                if (pending_lines.size() > 0 && (calm_phase || $urandom_range(0, 99) >= 18)) begin
                    i_in_data  <= pending_lines.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            if (i_in_valid && o_in_ready) begin
                expected_hits.push_back(intersect_lines(i_in_data));
                n_sent++;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        lix_pkg::t_out want;
        if (i_rst_n) begin
            i_out_ready <= calm_phase || ($urandom_range(0, 99) >= 18);
            if (o_out_valid && i_out_ready) begin
                if (expected_hits.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10) $display("unexpected transfer: %p", o_out_data);
                end else begin
                    want = expected_hits.pop_front();
                    if (want.hit_valid != o_out_data.hit_valid || want.hit_x != o_out_data.hit_x
                        || want.hit_y != o_out_data.hit_y
                        || want.saturated != o_out_data.saturated) begin
                        n_mismatch++;
                        if (n_mismatch <= 10)
                            $display("mismatch at %0d: expected %p actual %p",
                                     n_checked, want, o_out_data);
                    end
                    if (!want.hit_valid) n_parallel++;
                    if (want.saturated) n_clamped++;
                    n_checked++;
                end
            end
        end
    end

    initial begin
        wait (stim_done && expected_hits.size() == 0);
        repeat (lix_pkg::PIPE_LAT + 20) @(posedge i_clk);
        $display("checked %0d of %0d line pairs: %0d parallel, %0d clamped",
                 n_checked, n_sent, n_parallel, n_clamped);
        if (n_mismatch == 0 && expected_hits.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", n_mismatch);
            $display("== FAIL ==");
        end
        $finish;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end
endmodule
